@@ hw/rtl/sdc_pkg.sv @@
// Package for the serial date to calendar converter.
// Fixed-point format, calendar constants, reciprocals and month table.
// No dependencies.
`default_nettype none

package sdc_pkg;

   localparam int IN_W      = 55;
   localparam int FRAC_BITS = 32;
   localparam int DAY_W     = 22;
   localparam int MS_W      = 27;
   localparam int PROD_W    = FRAC_BITS + MS_W;
   localparam int SEC_W     = 17;
   localparam int MIN_W     = 11;
   localparam int RW        = 64;
   localparam int RSH       = 32;
   localparam int NSTAGE    = 13;

   localparam int MAX_DAY    = 2958465;
   localparam int MIN_DAY    = 657434;
   localparam int EPOCH      = 693959;
   localparam int D400       = 146097;
   localparam int D100       = 36524;
   localparam int D4         = 1461;
   localparam int D1         = 365;
   localparam int MS_PER_DAY = 86400000;

   localparam logic signed [IN_W-1:0] MAX_FX = $signed(IN_W'(MAX_DAY) << FRAC_BITS);
   localparam logic signed [IN_W-1:0] MIN_FX = $signed(-(IN_W'(MIN_DAY) << FRAC_BITS));
   localparam logic [PROD_W:0] HALF_LSB = (PROD_W+1)'(1) << (FRAC_BITS - 1);

   // floor(2^32 / d): estimate is exact or one low
   localparam logic [RW-1:0] R400  = (RW'(1) << RSH) / RW'(D400);
   localparam logic [RW-1:0] R4    = (RW'(1) << RSH) / RW'(D4);
   localparam logic [RW-1:0] R7    = (RW'(1) << RSH) / RW'(7);
   localparam logic [RW-1:0] R1000 = (RW'(1) << RSH) / RW'(1000);
   localparam logic [RW-1:0] R60   = (RW'(1) << RSH) / RW'(60);

   localparam logic [8:0] CUM_DAYS [13] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
      9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
   };

endpackage

`default_nettype wire

@@ hw/rtl/serial_date_to_calendar.sv @@
// Serial date to calendar converter, 13-stage pipeline.
// Depends on sdc_pkg.
//
// Converts a signed serial date (days since 1899-12-30, FRAC_BITS fraction bits)
// into Gregorian date, time of day and weekday. One item is accepted every
// cycle (busy stays low); its result appears on the rsp_ ports, marked by
// rsp_strobe. The depth of the pipeline is set by the chain of constant
// divisions (reciprocal multiply, then a correction stage each).
// Results come out in order and cannot be held off. An out-of-range date
// gives a result with every field zero, rsp_valid_res included.
`default_nettype none

module serial_date_to_calendar import sdc_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic signed [IN_W-1:0] req_serial_date,
   output logic                        rsp_strobe,
   output logic                        rsp_valid_res,
   output logic [13:0]                 rsp_year,
   output logic [3:0]                  rsp_month,
   output logic [4:0]                  rsp_day_of_month,
   output logic [4:0]                  rsp_hour,
   output logic [5:0]                  rsp_minute,
   output logic [5:0]                  rsp_second,
   output logic [9:0]                  rsp_millisecond,
   output logic [2:0]                  rsp_weekday
);

   logic [NSTAGE-1:0] vld_ff, vld_in;
   logic [NSTAGE-1:0] inr_ff, inr_in;

   // stage 1
   logic [IN_W-1:0]      mag1;
   logic                 neg1_ff;
   logic [DAY_W-1:0]     ip1_ff;
   logic [FRAC_BITS-1:0] fr1_ff;
   // stage 2
   logic                 neg2_ff;
   logic [DAY_W-1:0]     ip2_ff;
   logic [PROD_W-1:0]    prod2_ff;
   // stage 3
   logic [PROD_W:0]      sum3;
   logic                 neg3_ff;
   logic [DAY_W-1:0]     ip3_ff;
   logic [MS_W-1:0]      msr3_ff;
   // stage 4
   logic                 wrap4;
   logic                 neg4_ff;
   logic [DAY_W-1:0]     ip4_ff, ip4_in;
   logic [MS_W-1:0]      ms4_ff, ms4_in;
   // stage 5
   logic [RW-1:0]        mp5;
   logic [DAY_W-1:0]     a5_ff, a5_in;
   logic [MS_W-1:0]      ms5_ff;
   logic [SEC_W-1:0]     mq5_ff;
   // stage 6
   logic [RW-1:0]        qp6, wp6;
   logic [DAY_W-1:0]     am6;
   logic [MS_W-1:0]      mr6;
   logic [DAY_W-1:0]     a6_ff;
   logic [4:0]           q400e6_ff;
   logic [19:0]          wq6_ff;
   logic [9:0]           msec6_ff, msec6_in;
   logic [SEC_W-1:0]     st6_ff, st6_in;
   // stage 7
   logic [DAY_W-1:0]     r7, wr7;
   logic [RW-1:0]        sp7;
   logic [17:0]          a7_ff, a7_in;
   logic [4:0]           q400_7_ff, q400_7_in;
   logic [2:0]           wd7_ff, wd7_in;
   logic [9:0]           msec7_ff;
   logic [SEC_W-1:0]     st7_ff;
   logic [MIN_W-1:0]     sq7_ff;
   // stage 8
   logic [17:0]          t8;
   logic [SEC_W-1:0]     sr8;
   logic [15:0]          a8_ff, a8_in;
   logic [1:0]           cent8_ff, cent8_in;
   logic [4:0]           q400_8_ff;
   logic [2:0]           wd8_ff;
   logic [9:0]           msec8_ff;
   logic [5:0]           sec8_ff, sec8_in;
   logic [MIN_W-1:0]     mt8_ff, mt8_in;
   // stage 9
   logic [15:0]          v9_in;
   logic [RW-1:0]        qp9, hp9;
   logic [15:0]          v9_ff;
   logic [1:0]           cent9_ff;
   logic [4:0]           q4e9_ff;
   logic [4:0]           q400_9_ff;
   logic [2:0]           wd9_ff;
   logic [9:0]           msec9_ff;
   logic [5:0]           sec9_ff;
   logic [MIN_W-1:0]     mt9_ff;
   logic [4:0]           hq9_ff;
   // stage 10
   logic [15:0]          r10;
   logic [4:0]           q4c10;
   logic [MIN_W-1:0]     mr10;
   logic [10:0]          d4_10_ff, d4_10_in;
   logic                 leap10_ff, leap10_in;
   logic [4:0]           q4_10_ff, q4_10_in;
   logic [1:0]           cent10_ff;
   logic [4:0]           q400_10_ff;
   logic [2:0]           wd10_ff;
   logic [9:0]           msec10_ff;
   logic [5:0]           sec10_ff;
   logic [5:0]           min10_ff, min10_in;
   logic [4:0]           hr10_ff, hr10_in;
   // stage 11
   logic [10:0]          t11;
   logic [8:0]           d4_11_ff, d4_11_in;
   logic [1:0]           y4_11_ff, y4_11_in;
   logic                 leap11_ff;
   logic [4:0]           q4_11_ff;
   logic [1:0]           cent11_ff;
   logic [4:0]           q400_11_ff;
   logic [2:0]           wd11_ff;
   logic [9:0]           msec11_ff;
   logic [5:0]           sec11_ff;
   logic [5:0]           min11_ff;
   logic [4:0]           hr11_ff;
   // stage 12
   logic                 first11;
   logic                 feb12_ff;
   logic [8:0]           dp12_ff, dp12_in;
   logic [13:0]          year12_ff, year12_in;
   logic [2:0]           wd12_ff;
   logic [9:0]           msec12_ff;
   logic [5:0]           sec12_ff;
   logic [5:0]           min12_ff;
   logic [4:0]           hr12_ff;
   // stage 13 (output)
   logic [10:0]          gt13;
   logic [3:0]           m13;
   logic [4:0]           dom13;
   logic [13:0]          year_ff;
   logic [3:0]           month_ff, month_in;
   logic [4:0]           dom_ff, dom_in;
   logic [4:0]           hour_ff;
   logic [5:0]           minute_ff;
   logic [5:0]           second_ff;
   logic [9:0]           msec_ff;
   logic [2:0]           wday_ff;

   assign busy = 1'b0;

   // ---- control: valid and range flags travel with the item
   always_comb begin
      vld_in = {vld_ff[NSTAGE-2:0], start};
      inr_in = {inr_ff[NSTAGE-2:0],
                (req_serial_date <= MAX_FX) && (req_serial_date >= MIN_FX)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      inr_ff <= inr_in;
   end

   // ---- stages 1..4: magnitude, fraction to milliseconds, rounding carry
   assign mag1 = req_serial_date[IN_W-1] ? IN_W'(-req_serial_date)
                                         : IN_W'(req_serial_date);
   assign sum3 = (PROD_W+1)'(prod2_ff) + HALF_LSB;

   always_comb begin
      wrap4  = msr3_ff >= MS_W'(MS_PER_DAY);
      ms4_in = wrap4 ? (msr3_ff - MS_W'(MS_PER_DAY)) : msr3_ff;
      ip4_in = ip3_ff + DAY_W'(wrap4);
   end

   always_ff @(posedge clock) begin
      neg1_ff  <= req_serial_date[IN_W-1];
      ip1_ff   <= mag1[FRAC_BITS +: DAY_W];
      fr1_ff   <= mag1[FRAC_BITS-1:0];
      neg2_ff  <= neg1_ff;
      ip2_ff   <= ip1_ff;
      prod2_ff <= PROD_W'(fr1_ff) * PROD_W'(MS_PER_DAY);
      neg3_ff  <= neg2_ff;
      ip3_ff   <= ip2_ff;
      msr3_ff  <= sum3[FRAC_BITS +: MS_W];
      neg4_ff  <= neg3_ff;
      ip4_ff   <= ip4_in;
      ms4_ff   <= ms4_in;
   end

   // ---- stage 5: absolute day number, ms/1000 estimate
   always_comb begin
      a5_in = neg4_ff ? (DAY_W'(EPOCH) - ip4_ff) : (DAY_W'(EPOCH) + ip4_ff);
      mp5   = RW'(ms4_ff) * R1000;
   end

   always_ff @(posedge clock) begin
      a5_ff  <= a5_in;
      ms5_ff <= ms4_ff;
      mq5_ff <= mp5[RSH +: SEC_W];
   end

   // ---- stage 6: 400-year and weekday estimates, millisecond correction
   always_comb begin
      am6 = a5_ff - DAY_W'(1);
      qp6 = RW'(a5_ff) * R400;
      wp6 = RW'(am6) * R7;
      mr6 = ms5_ff - MS_W'(mq5_ff) * MS_W'(1000);
      if (mr6 >= MS_W'(1000)) begin
         msec6_in = 10'(mr6 - MS_W'(1000));
         st6_in   = mq5_ff + SEC_W'(1);
      end else begin
         msec6_in = 10'(mr6);
         st6_in   = mq5_ff;
      end
   end

   always_ff @(posedge clock) begin
      a6_ff     <= a5_ff;
      q400e6_ff <= qp6[RSH +: 5];
      wq6_ff    <= wp6[RSH +: 20];
      msec6_ff  <= msec6_in;
      st6_ff    <= st6_in;
   end

   // ---- stage 7: 400-year and weekday correction, seconds/60 estimate
   always_comb begin
      r7  = a6_ff - DAY_W'(q400e6_ff) * DAY_W'(D400);
      wr7 = (a6_ff - DAY_W'(1)) - DAY_W'(wq6_ff) * DAY_W'(7);
      if (r7 >= DAY_W'(D400)) begin
         a7_in     = 18'(r7 - DAY_W'(D400));
         q400_7_in = q400e6_ff + 5'd1;
      end else begin
         a7_in     = 18'(r7);
         q400_7_in = q400e6_ff;
      end
      if (wr7 >= DAY_W'(7)) begin
         wd7_in = 3'(wr7 - DAY_W'(7)) + 3'd1;
      end else begin
         wd7_in = 3'(wr7) + 3'd1;
      end
      sp7 = RW'(st6_ff) * R60;
   end

   always_ff @(posedge clock) begin
      a7_ff     <= a7_in;
      q400_7_ff <= q400_7_in;
      wd7_ff    <= wd7_in;
      msec7_ff  <= msec6_ff;
      st7_ff    <= st6_ff;
      sq7_ff    <= sp7[RSH +: MIN_W];
   end

   // ---- stage 8: century within the 400-year cycle, second correction
   always_comb begin
      t8 = a7_ff - 18'd1;
      if (a7_ff == 18'd0) begin
         cent8_in = 2'd0;
      end else if (t8 >= 18'(3 * D100)) begin
         cent8_in = 2'd3;
      end else if (t8 >= 18'(2 * D100)) begin
         cent8_in = 2'd2;
      end else if (t8 >= 18'(D100)) begin
         cent8_in = 2'd1;
      end else begin
         cent8_in = 2'd0;
      end
      if (cent8_in != 2'd0) begin
         a8_in = 16'(t8 - 18'(cent8_in) * 18'(D100));
      end else begin
         a8_in = 16'(a7_ff);
      end
      sr8 = st7_ff - SEC_W'(sq7_ff) * SEC_W'(60);
      if (sr8 >= SEC_W'(60)) begin
         sec8_in = 6'(sr8 - SEC_W'(60));
         mt8_in  = sq7_ff + MIN_W'(1);
      end else begin
         sec8_in = 6'(sr8);
         mt8_in  = sq7_ff;
      end
   end

   always_ff @(posedge clock) begin
      a8_ff     <= a8_in;
      cent8_ff  <= cent8_in;
      q400_8_ff <= q400_7_ff;
      wd8_ff    <= wd7_ff;
      msec8_ff  <= msec7_ff;
      sec8_ff   <= sec8_in;
      mt8_ff    <= mt8_in;
   end

   // ---- stage 9: 4-year estimate, minutes/60 estimate
   always_comb begin
      v9_in = (cent8_ff != 2'd0) ? (a8_ff + 16'd1) : a8_ff;
      qp9   = RW'(v9_in) * R4;
      hp9   = RW'(mt8_ff) * R60;
   end

   always_ff @(posedge clock) begin
      v9_ff     <= v9_in;
      cent9_ff  <= cent8_ff;
      q4e9_ff   <= qp9[RSH +: 5];
      q400_9_ff <= q400_8_ff;
      wd9_ff    <= wd8_ff;
      msec9_ff  <= msec8_ff;
      sec9_ff   <= sec8_ff;
      mt9_ff    <= mt8_ff;
      hq9_ff    <= hp9[RSH +: 5];
   end

   // ---- stage 10: 4-year correction, leap flag, minute/hour correction
   always_comb begin
      r10 = v9_ff - 16'(q4e9_ff) * 16'(D4);
      if (r10 >= 16'(D4)) begin
         r10   = r10 - 16'(D4);
         q4c10 = q4e9_ff + 5'd1;
      end else begin
         q4c10 = q4e9_ff;
      end
      q4_10_in = q4c10;
      // first 4-year block of a non-leap century has no leap day
      if ((cent9_ff != 2'd0) && (q4c10 == 5'd0)) begin
         leap10_in = 1'b0;
         d4_10_in  = 11'(v9_ff - 16'd1);
      end else begin
         leap10_in = 1'b1;
         d4_10_in  = 11'(r10);
      end
      mr10 = mt9_ff - MIN_W'(hq9_ff) * MIN_W'(60);
      if (mr10 >= MIN_W'(60)) begin
         min10_in = 6'(mr10 - MIN_W'(60));
         hr10_in  = hq9_ff + 5'd1;
      end else begin
         min10_in = 6'(mr10);
         hr10_in  = hq9_ff;
      end
   end

   always_ff @(posedge clock) begin
      d4_10_ff   <= d4_10_in;
      leap10_ff  <= leap10_in;
      q4_10_ff   <= q4_10_in;
      cent10_ff  <= cent9_ff;
      q400_10_ff <= q400_9_ff;
      wd10_ff    <= wd9_ff;
      msec10_ff  <= msec9_ff;
      sec10_ff   <= sec9_ff;
      min10_ff   <= min10_in;
      hr10_ff    <= hr10_in;
   end

   // ---- stage 11: year within the 4-year block
   always_comb begin
      t11 = d4_10_ff - 11'd1;
      if (leap10_ff) begin
         if (d4_10_ff == 11'd0) begin
            y4_11_in = 2'd0;
         end else if (t11 >= 11'(3 * D1)) begin
            y4_11_in = 2'd3;
         end else if (t11 >= 11'(2 * D1)) begin
            y4_11_in = 2'd2;
         end else if (t11 >= 11'(D1)) begin
            y4_11_in = 2'd1;
         end else begin
            y4_11_in = 2'd0;
         end
         if (y4_11_in != 2'd0) begin
            d4_11_in = 9'(t11 - 11'(y4_11_in) * 11'(D1));
         end else begin
            d4_11_in = 9'(d4_10_ff);
         end
      end else begin
         if (d4_10_ff >= 11'(3 * D1)) begin
            y4_11_in = 2'd3;
         end else if (d4_10_ff >= 11'(2 * D1)) begin
            y4_11_in = 2'd2;
         end else if (d4_10_ff >= 11'(D1)) begin
            y4_11_in = 2'd1;
         end else begin
            y4_11_in = 2'd0;
         end
         d4_11_in = 9'(d4_10_ff - 11'(y4_11_in) * 11'(D1));
      end
   end

   always_ff @(posedge clock) begin
      d4_11_ff   <= d4_11_in;
      y4_11_ff   <= y4_11_in;
      leap11_ff  <= leap10_ff;
      q4_11_ff   <= q4_10_ff;
      cent11_ff  <= cent10_ff;
      q400_11_ff <= q400_10_ff;
      wd11_ff    <= wd10_ff;
      msec11_ff  <= msec10_ff;
      sec11_ff   <= sec10_ff;
      min11_ff   <= min10_ff;
      hr11_ff    <= hr10_ff;
   end

   // ---- stage 12: year number, day of year with the leap day taken out
   always_comb begin
      first11   = (y4_11_ff == 2'd0) && leap11_ff;
      dp12_in   = d4_11_ff - 9'((first11 && (d4_11_ff >= 9'd60)) ? 1 : 0) + 9'd1;
      year12_in = 14'(q400_11_ff) * 14'd400 + 14'(cent11_ff) * 14'd100
                + 14'(q4_11_ff) * 14'd4 + 14'(y4_11_ff);
   end

   always_ff @(posedge clock) begin
      feb12_ff  <= first11 && (d4_11_ff == 9'd59);
      dp12_ff   <= dp12_in;
      year12_ff <= year12_in;
      wd12_ff   <= wd11_ff;
      msec12_ff <= msec11_ff;
      sec12_ff  <= sec11_ff;
      min12_ff  <= min11_ff;
      hr12_ff   <= hr11_ff;
   end

   // ---- stage 13: month lookup, zeroing of out-of-range items
   always_comb begin
      for (int k = 0; k < 11; k++) begin
         gt13[k] = dp12_ff > CUM_DAYS[k+1];
      end
      m13   = 4'd1 + 4'($countones(gt13));
      dom13 = 5'(dp12_ff - CUM_DAYS[m13 - 4'd1]);
      if (!inr_ff[NSTAGE-2]) begin
         month_in = 4'd0;
         dom_in   = 5'd0;
      end else if (feb12_ff) begin
         month_in = 4'd2;
         dom_in   = 5'd29;
      end else begin
         month_in = m13;
         dom_in   = dom13;
      end
   end

   always_ff @(posedge clock) begin
      month_ff  <= month_in;
      dom_ff    <= dom_in;
      year_ff   <= inr_ff[NSTAGE-2] ? year12_ff : 14'd0;
      wday_ff   <= inr_ff[NSTAGE-2] ? wd12_ff   : 3'd0;
      msec_ff   <= inr_ff[NSTAGE-2] ? msec12_ff : 10'd0;
      second_ff <= inr_ff[NSTAGE-2] ? sec12_ff  : 6'd0;
      minute_ff <= inr_ff[NSTAGE-2] ? min12_ff  : 6'd0;
      hour_ff   <= inr_ff[NSTAGE-2] ? hr12_ff   : 5'd0;
   end

   assign rsp_strobe       = vld_ff[NSTAGE-1];
   assign rsp_valid_res    = inr_ff[NSTAGE-1];
   assign rsp_year         = year_ff;
   assign rsp_month        = month_ff;
   assign rsp_day_of_month = dom_ff;
   assign rsp_hour         = hour_ff;
   assign rsp_minute       = minute_ff;
   assign rsp_second       = second_ff;
   assign rsp_millisecond  = msec_ff;
   assign rsp_weekday      = wday_ff;

endmodule

`default_nettype wire
